// ===== hw/rtl/qcbk_pkg.sv =====
// Package for the queue with cancel by key: sizes, request and result words,
// mode and status codes, and the control word broadcast to the cell chain.
// Depends on nothing; every other file refers to it by scoped names.
package qcbk_pkg;

	localparam int DEPTH = 16;
	localparam int VAL_W = 16;
	localparam int OCC_W = $clog2(DEPTH + 1);

	localparam logic [1:0] MODE_ENQUEUE = 2'd0;
	localparam logic [1:0] MODE_CANCEL  = 2'd1;
	localparam logic [1:0] MODE_READ    = 2'd2;

	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_ENTRY    = 3'd4;

	typedef struct packed {
		logic [1:0]       mode;
		logic [VAL_W-1:0] number;
	} in_word_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [VAL_W-1:0] entry_value;
		logic             last;
	} out_word_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_CANCEL,
		OP_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [VAL_W-1:0] key;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/queue_with_cancel_by_key.sv =====
// Queue with cancel by key: enqueue and cancel give their one result word in the
// cycle after the request is accepted and accept a new request every cycle while busy is low.
// Read-out of an empty queue gives one empty word in the cycle after acceptance;
// otherwise the state moves to read-out, then one word per entry is registered from the head cell while busy is high.
// Asynchronous active-low reset empties the queue; the receiver cannot stall,
// so each result word is on the ports for exactly one cycle.
module queue_with_cancel_by_key (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  qcbk_pkg::in_word_t   request,
	output logic                 result_valid,
	output qcbk_pkg::out_word_t  result
);

	// The queue lives in a row of cells, head at cell 0. Valid cells always
	// form an unbroken run from the head, and occ_q tracks its length.
	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t                               state_q;
	logic [qcbk_pkg::OCC_W-1:0]           occ_q;
	logic [qcbk_pkg::OCC_W-1:0]           rd_cnt_q;
	logic                                 result_valid_q;
	qcbk_pkg::out_word_t                  result_q;

	qcbk_pkg::cell_ctl_t                  ctl;
	logic                                 accept;
	logic                                 full;
	logic                                 hit_any;
	logic [qcbk_pkg::DEPTH-1:0]           cell_valid;
	logic [qcbk_pkg::VAL_W-1:0]           cell_value [qcbk_pkg::DEPTH];
	logic [qcbk_pkg::DEPTH:0]             hit;

	assign busy    = (state_q == S_READ);
	assign accept  = start && !busy;
	assign full    = (occ_q == qcbk_pkg::OCC_W'(qcbk_pkg::DEPTH));
	assign hit_any = hit[qcbk_pkg::DEPTH];
	assign hit[0]  = 1'b0;

	// During read-out the chain rotates by one place each cycle: the head
	// word leaves on the result port and re-enters at the tail, so after
	// every entry has been shown the queue is back in its original order.
	always_comb begin
		ctl.key = request.number;
		ctl.op  = qcbk_pkg::OP_NONE;
		if (busy) begin
			ctl.op = qcbk_pkg::OP_ROTATE;
		end else if (accept) begin
			case (request.mode)
				qcbk_pkg::MODE_ENQUEUE: ctl.op = qcbk_pkg::OP_PUSH;
				qcbk_pkg::MODE_CANCEL:  ctl.op = qcbk_pkg::OP_CANCEL;
				default:                ctl.op = qcbk_pkg::OP_NONE;
			endcase
		end
	end

	for (genvar i = 0; i < qcbk_pkg::DEPTH; i++) begin : g_cell
		logic                       lv;
		logic                       rv;
		logic [qcbk_pkg::VAL_W-1:0] rval;

		if (i == 0) begin : g_head
			assign lv = 1'b1;
		end else begin : g_body
			assign lv = cell_valid[i-1];
		end

		if (i == qcbk_pkg::DEPTH - 1) begin : g_tail
			assign rv   = 1'b0;
			assign rval = '0;
		end else begin : g_link
			assign rv   = cell_valid[i+1];
			assign rval = cell_value[i+1];
		end

		qcbk_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_valid  (lv),
			.right_valid (rv),
			.right_value (rval),
			.head_value  (cell_value[0]),
			.hit_in      (hit[i]),
			.hit_out     (hit[i+1]),
			.valid       (cell_valid[i]),
			.value       (cell_value[i])
		);
	end

	// Sequencer: holds the occupancy, the read-out count and the registered
	// result word. A request with the unused mode code gives no result word and leaves the queue as it is.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			occ_q          <= '0;
			rd_cnt_q       <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						result_q.entry_value <= '0;
						result_q.last        <= 1'b1;
						unique case (request.mode)
							qcbk_pkg::MODE_ENQUEUE: begin
								result_valid_q <= 1'b1;
								if (full) begin
									result_q.status <= qcbk_pkg::ST_FULL;
								end else begin
									result_q.status <= qcbk_pkg::ST_DONE;
									occ_q           <= occ_q + qcbk_pkg::OCC_W'(1);
								end
							end
							qcbk_pkg::MODE_CANCEL: begin
								result_valid_q <= 1'b1;
								if (hit_any) begin
									result_q.status <= qcbk_pkg::ST_DONE;
									occ_q           <= occ_q - qcbk_pkg::OCC_W'(1);
								end else begin
									result_q.status <= qcbk_pkg::ST_NOTFOUND;
								end
							end
							qcbk_pkg::MODE_READ: begin
								if (occ_q == '0) begin
									result_valid_q  <= 1'b1;
									result_q.status <= qcbk_pkg::ST_EMPTY;
								end else begin
									state_q  <= S_READ;
									rd_cnt_q <= occ_q;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					result_valid_q       <= 1'b1;
					result_q.status      <= qcbk_pkg::ST_ENTRY;
					result_q.entry_value <= cell_value[0];
					result_q.last        <= (rd_cnt_q == qcbk_pkg::OCC_W'(1));
					rd_cnt_q             <= rd_cnt_q - qcbk_pkg::OCC_W'(1);
					if (rd_cnt_q == qcbk_pkg::OCC_W'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// The count of valid cells always agrees with the tracked occupancy.
	a_occ_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == occ_q)
		else $error("cell valid flags disagree with occupancy");

	// Occupancy never exceeds the number of cells.
	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= qcbk_pkg::OCC_W'(qcbk_pkg::DEPTH))
		else $error("occupancy above depth");

	// A read-out in progress always has entries left to show.
	a_read_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (rd_cnt_q != '0) && (rd_cnt_q <= occ_q))
		else $error("read-out count out of range");

	// A successful cancel removes exactly one entry.
	a_cancel_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && request.mode == qcbk_pkg::MODE_CANCEL && hit_any)
		|=> occ_q == $past(occ_q) - qcbk_pkg::OCC_W'(1))
		else $error("cancel hit did not remove one entry");

	// Every read-out cycle produces a result word in the next cycle.
	a_read_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> result_valid && result.status == qcbk_pkg::ST_ENTRY)
		else $error("read-out cycle without an entry word");
`endif

endmodule

// ===== hw/rtl/qcbk_cell.sv =====
// One position of the queue: a valid flag and a stored number, updated from
// the broadcast control word, both neighbors and the head cell's value.
// Depends on qcbk_pkg.
module qcbk_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  qcbk_pkg::cell_ctl_t       ctl,
	input  logic                      left_valid,
	input  logic                      right_valid,
	input  logic [qcbk_pkg::VAL_W-1:0] right_value,
	input  logic [qcbk_pkg::VAL_W-1:0] head_value,
	input  logic                      hit_in,
	output logic                      hit_out,
	output logic                      valid,
	output logic [qcbk_pkg::VAL_W-1:0] value
);

	logic                       valid_q;
	logic [qcbk_pkg::VAL_W-1:0] value_q;
	logic                       match;
	logic                       take_right;
	logic                       do_push;
	logic                       do_rotate;

	// A cancel removes the first match; this cell and every one after it
	// pull from the right neighbor, which closes the gap.
	assign match      = valid_q && (value_q == ctl.key);
	assign hit_out    = hit_in || match;
	assign take_right = (ctl.op == qcbk_pkg::OP_CANCEL) && hit_out;
	assign do_push    = (ctl.op == qcbk_pkg::OP_PUSH) && !valid_q && left_valid;
	assign do_rotate  = (ctl.op == qcbk_pkg::OP_ROTATE) && valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_right) begin
			valid_q <= right_valid;
		end else if (do_push) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_right) begin
			value_q <= right_value;
		end else if (do_push) begin
			value_q <= ctl.key;
		end else if (do_rotate) begin
			value_q <= right_valid ? right_value : head_value;
		end
	end

	assign valid = valid_q;
	assign value = value_q;

endmodule

// ===== tb/tb_queue_with_cancel_by_key.sv =====
// Self-checking testbench for queue_with_cancel_by_key: a directed opening, then random
// enqueue, cancel, read-out and unused-mode requests with random or zero gaps, all checked word by word.
// Depends on qcbk_pkg and the queue_with_cancel_by_key and qcbk_cell RTL only.
module tb_queue_with_cancel_by_key;
	timeunit 1ns;
	timeprecision 1ps;

	// The mode value three has no name in the package; the block ignores it.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 200;
	localparam int SETTLE_CYCLES = qcbk_pkg::DEPTH + 8;
	localparam int MAX_PRINTS = 30;

	typedef struct {
		qcbk_pkg::in_word_t word;
		int unsigned        gap;
		bit                 drain;
	} pending_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	qcbk_pkg::in_word_t  request;
	logic                result_valid;
	qcbk_pkg::out_word_t result;

	queue_with_cancel_by_key i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_valid (result_valid),
		.result       (result)
	);

	always #6 clk = ~clk;

	// Stimulus waiting to be sent, the predicted queue contents, and the result words
	// that the predicted contents say must still come out of the block.
	pending_t                   pending_requests[$];
	logic [qcbk_pkg::VAL_W-1:0] queue_model[$];
	qcbk_pkg::out_word_t        expected_results[$];

	int unsigned total_requests;
	int unsigned accepted_count;
	int unsigned words_checked;
	int unsigned error_count;
	int unsigned enqueue_count, cancel_count, readout_count, ignored_count;
	int unsigned full_drops, missed_cancels, entries_read;
	bit          zero_gaps;

	// Driver state; only the driver writes these, except word_taken, which the
	// monitor raises at the edge where the block takes a word, and want, the monitor's own scratch word.
	pending_t            next_item;
	bit                  have_next;
	bit                  word_taken;
	int unsigned         gap_left;
	logic                drive_start;
	qcbk_pkg::in_word_t  drive_word;
	qcbk_pkg::out_word_t want;

	task automatic report_mismatch(input string what, input logic [qcbk_pkg::VAL_W-1:0] got,
			input logic [qcbk_pkg::VAL_W-1:0] wanted);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("[%0t] result word %0d: %s is %h, expected %h",
				$realtime, words_checked, what, got, wanted);
	endtask

	// Predicts the effect of one accepted request on the queue and appends the
	// result words that it must produce, in order.
	function automatic void predict_request(input qcbk_pkg::in_word_t w);
		qcbk_pkg::out_word_t r;
		int                  hit;
		r = '0;
		r.last = 1'b1;
		hit = -1;
		case (w.mode)
		qcbk_pkg::MODE_ENQUEUE: begin
			enqueue_count++;
			if (queue_model.size() >= qcbk_pkg::DEPTH) begin
				r.status = qcbk_pkg::ST_FULL;
			end else begin
				queue_model.push_back(w.number);
				r.status = qcbk_pkg::ST_DONE;
			end
			expected_results.push_back(r);
		end
		qcbk_pkg::MODE_CANCEL: begin
			cancel_count++;
			// Only the match nearest the head goes; later duplicates stay put.
			foreach (queue_model[i])
				if (hit < 0 && queue_model[i] == w.number)
					hit = i;
			if (hit >= 0) begin
				queue_model.delete(hit);
				r.status = qcbk_pkg::ST_DONE;
			end else begin
				r.status = qcbk_pkg::ST_NOTFOUND;
			end
			expected_results.push_back(r);
		end
		qcbk_pkg::MODE_READ: begin
			readout_count++;
			if (queue_model.size() == 0) begin
				r.status = qcbk_pkg::ST_EMPTY;
				expected_results.push_back(r);
			end else begin
				foreach (queue_model[i]) begin
					r.status = qcbk_pkg::ST_ENTRY;
					r.entry_value = queue_model[i];
					r.last = (i == queue_model.size() - 1);
					expected_results.push_back(r);
				end
			end
		end
		default: begin
			ignored_count++;
		end
		endcase
	endfunction

	task automatic queue_request(input logic [1:0] mode,
			input logic [qcbk_pkg::VAL_W-1:0] number, input bit drain);
		pending_t p;
		p.word.mode = mode;
		p.word.number = number;
		p.gap = zero_gaps ? 0 : $urandom_range(0, 18);
		p.drain = drain;
		pending_requests.push_back(p);
	endtask

	task automatic build_stimulus();
		logic [qcbk_pkg::VAL_W-1:0] key_pool[8];
		logic [qcbk_pkg::VAL_W-1:0] number;
		logic [1:0]                 mode;
		int unsigned                counted;
		int unsigned                phase;
		int unsigned                roll;

		// Directed opening: an empty queue first, then duplicates, a miss, a full
		// queue and removal at both ends.
		zero_gaps = 1'b0;
		queue_request(qcbk_pkg::MODE_READ, 16'h0000, 1'b0);
		queue_request(qcbk_pkg::MODE_CANCEL, 16'h0000, 1'b0);
		queue_request(MODE_UNUSED, 16'hFFFF, 1'b0);
		queue_request(qcbk_pkg::MODE_ENQUEUE, 16'h0000, 1'b0);
		queue_request(qcbk_pkg::MODE_ENQUEUE, 16'hFFFF, 1'b0);
		queue_request(qcbk_pkg::MODE_ENQUEUE, 16'h1234, 1'b0);
		queue_request(qcbk_pkg::MODE_ENQUEUE, 16'hFFFF, 1'b0);
		queue_request(qcbk_pkg::MODE_CANCEL, 16'hFFFF, 1'b0);
		queue_request(qcbk_pkg::MODE_CANCEL, 16'h5555, 1'b0);
		queue_request(qcbk_pkg::MODE_READ, 16'hFFFF, 1'b0);
		for (int i = 0; i < qcbk_pkg::DEPTH - 3; i++)
			queue_request(qcbk_pkg::MODE_ENQUEUE, 16'(16'hC000 + i), 1'b0);
		queue_request(qcbk_pkg::MODE_ENQUEUE, 16'h7777, 1'b0);
		// The sender holds this read-out back until the queue has gone quiet.
		queue_request(qcbk_pkg::MODE_READ, 16'h0000, 1'b1);
		queue_request(qcbk_pkg::MODE_CANCEL, 16'(16'hC000 + qcbk_pkg::DEPTH - 4), 1'b0);
		queue_request(qcbk_pkg::MODE_CANCEL, 16'h0000, 1'b0);

		// Random part. A small pool of keys makes cancels hit often and makes
		// duplicates common; the rest of the numbers are fully random.
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		for (int i = 2; i < 8; i++)
			key_pool[i] = 16'($urandom);
		counted = 0;
		while (counted < RANDOM_WORDS) begin
			// Phases lean toward filling, mixing or draining so that both the
			// full and the empty queue come up repeatedly.
			phase = (counted / 25) % 3;
			zero_gaps = ((counted / 40) % 2) == 1;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				mode = MODE_UNUSED;
			else if (roll < 20)
				mode = qcbk_pkg::MODE_READ;
			else if (phase == 0)
				mode = (roll < 88) ? qcbk_pkg::MODE_ENQUEUE : qcbk_pkg::MODE_CANCEL;
			else if (phase == 1)
				mode = (roll < 60) ? qcbk_pkg::MODE_ENQUEUE : qcbk_pkg::MODE_CANCEL;
			else
				mode = (roll < 35) ? qcbk_pkg::MODE_ENQUEUE : qcbk_pkg::MODE_CANCEL;
			if ($urandom_range(0, 9) < 6)
				number = key_pool[3'($urandom_range(0, 7))];
			else
				number = 16'($urandom);
			queue_request(mode, number, (counted % 60) == 30);
			if (mode != MODE_UNUSED)
				counted++;
		end
	endtask

	// Driver: works at the falling edge. A word stays on the ports until the block
	// takes it; then the next one waits out its own gap, and a draining item also
	// waits until every expected word has come back.
	always @(negedge clk) begin
		drive_start = 1'b0;
		drive_word = request;
		if (arst_n) begin
			if (word_taken)
				word_taken = 1'b0;
			else if (start)
				drive_start = 1'b1;
			if (!drive_start) begin
				if (!have_next && pending_requests.size() != 0) begin
					next_item = pending_requests.pop_front();
					gap_left = next_item.gap;
					have_next = 1'b1;
				end
				if (have_next) begin
					if (gap_left != 0) begin
						gap_left--;
					end else if (!next_item.drain || expected_results.size() == 0) begin
						drive_start = 1'b1;
						drive_word = next_item.word;
						have_next = 1'b0;
					end
				end
			end
		end
		start <= drive_start;
		request <= drive_word;
	end

	// Monitor: works at the rising edge. Result words are checked against the oldest
	// expectation first; a word taken at this same edge cannot have results yet.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid === 1'b1) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected word", {13'd0, result.status},
						result.entry_value);
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status)
						report_mismatch("status", result.status, want.status);
					if (result.entry_value !== want.entry_value)
						report_mismatch("entry_value", result.entry_value,
							want.entry_value);
					if (result.last !== want.last)
						report_mismatch("last", result.last, want.last);
					case (want.status)
					qcbk_pkg::ST_FULL:     full_drops++;
					qcbk_pkg::ST_NOTFOUND: missed_cancels++;
					qcbk_pkg::ST_ENTRY:    entries_read++;
					default:               ;
					endcase
				end
				words_checked++;
			end else if (result_valid !== 1'b0) begin
				report_mismatch("result_valid", result_valid, 1'b0);
			end
			if (start === 1'b1 && busy === 1'b0) begin
				predict_request(request);
				accepted_count++;
				word_taken = 1'b1;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		build_stimulus();
		total_requests = pending_requests.size();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		while (accepted_count != total_requests)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// Any word the block still puts out after this is flagged by the monitor.
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d requests: %0d enqueue, %0d cancel, %0d read-out, %0d ignored.",
			accepted_count, enqueue_count, cancel_count, readout_count, ignored_count);
		$display("Checked %0d result words: %0d entries read, %0d full drops, %0d misses.",
			words_checked, entries_read, full_drops, missed_cancels);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Timed out with %0d of %0d requests taken.", accepted_count, total_requests);
		$display("== FAIL ==");
		$finish;
	end

endmodule
